/* sv/jpeg_exif_orientation_parser_core_defines.svh */
// Assertion macros shared by the Exif orientation parser modules.
// Included by every RTL file that carries concurrent checks; no other dependencies.
`ifndef JPEG_EXIF_ORIENTATION_PARSER_CORE_DEFINES_SVH
`define JPEG_EXIF_ORIENTATION_PARSER_CORE_DEFINES_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled while in reset
`define JEOP_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error("jeop check failed");
// Next-cycle implication, disabled while in reset
`define JEOP_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("jeop check failed");
`else
`define JEOP_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define JEOP_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif
`endif

/* sv/jeop_pkg.sv */
// Shared types and constants of the Exif orientation parser.
// No dependencies; imported by the parser, the output register and the core top level.
package jeop_pkg;

	// Status codes of a result
	localparam logic [2:0] ST_FOUND     = 3'd0;
	localparam logic [2:0] ST_RANGE     = 3'd1;
	localparam logic [2:0] ST_NOT_JPEG  = 3'd2;
	localparam logic [2:0] ST_TRUNC     = 3'd3;
	localparam logic [2:0] ST_BAD_MARK  = 3'd4;
	localparam logic [2:0] ST_EOI       = 3'd5;
	localparam logic [2:0] ST_ABSENT    = 3'd6;
	localparam logic [2:0] ST_BAD_LEN   = 3'd7;

	// Orientation given with every status but found
	localparam logic [3:0] ORIENT_DEFAULT = 4'd1;
	localparam logic [3:0] ORIENT_MAX     = 4'd8;

	// Output data width: orientation and status packed, padded to a byte
	localparam int unsigned TDATA_W = 8;

	// One result from the parser to the output register
	typedef struct packed {
		logic       valid;
		logic [2:0] status;
		logic [3:0] orientation;
	} result_t;

endpackage

/* sv/jeop_parser.sv */
// Byte-wise JPEG marker walker and Exif IFD0 orientation scanner.
// Depends on jeop_pkg and the core assertion macro header.
`include "jpeg_exif_orientation_parser_core_defines.svh"
module jeop_parser (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              take,
	input  logic [7:0]        data_byte,
	input  logic              first_byte,
	input  logic              last_byte,
	output jeop_pkg::result_t res
);
	import jeop_pkg::*;

	// Parse phases
	localparam logic [3:0] PH_SOI      = 4'd0;
	localparam logic [3:0] PH_MK0      = 4'd1;
	localparam logic [3:0] PH_MK1      = 4'd2;
	localparam logic [3:0] PH_LEN_SEG  = 4'd3;
	localparam logic [3:0] PH_LEN_APP1 = 4'd4;
	localparam logic [3:0] PH_SKIP_SEG = 4'd5;
	localparam logic [3:0] PH_EXHDR    = 4'd6;
	localparam logic [3:0] PH_TIFF     = 4'd7;
	localparam logic [3:0] PH_SKIP_IFD = 4'd8;
	localparam logic [3:0] PH_CNT      = 4'd9;
	localparam logic [3:0] PH_ENT      = 4'd10;

	localparam logic [7:0]  MK_PREFIX  = 8'hFF;
	localparam logic [7:0]  MK_SOI     = 8'hD8;
	localparam logic [7:0]  MK_APP1    = 8'hE1;
	localparam logic [7:0]  MK_EOI     = 8'hD9;
	localparam logic [7:0]  MK_STUFF   = 8'h00;
	localparam logic [7:0]  MK_RST_LO  = 8'hD0;
	localparam logic [7:0]  MK_RST_HI  = 8'hD7;
	localparam logic [7:0]  TIFF_LE    = 8'h49;
	localparam logic [31:0] TAG_ORIENT = 32'h0000_0112;
	localparam logic [31:0] TYPE_SHORT = 32'd3;
	localparam logic [31:0] COUNT_ONE  = 32'd1;

	// Exif header signature byte by position
	function automatic logic [7:0] exif_sig(input logic [2:0] idx);
		case (idx)
			3'd0:    exif_sig = 8'h45;
			3'd1:    exif_sig = 8'h78;
			3'd2:    exif_sig = 8'h69;
			3'd3:    exif_sig = 8'h66;
			default: exif_sig = 8'h00;
		endcase
	endfunction

	// Fold byte k of a TIFF-ordered field into the accumulator
	function automatic logic [31:0] tiff_acc(input logic [31:0] acc, input logic little,
		input logic [1:0] k, input logic [7:0] b);
		logic [31:0] bx;
		bx = {24'd0, b};
		if (k == 2'd0) begin
			tiff_acc = bx;
		end else if (little) begin
			case (k)
				2'd1:    tiff_acc = acc | (bx << 8);
				2'd2:    tiff_acc = acc | (bx << 16);
				default: tiff_acc = acc | (bx << 24);
			endcase
		end else begin
			tiff_acc = {acc[23:0], b};
		end
	endfunction

	logic [3:0]  phase_q, cur_phase, nxt_phase;
	logic [3:0]  pos_q, cur_pos, nxt_pos;
	logic [31:0] skip_q, cur_skip, nxt_skip;
	logic [31:0] acc_q, cur_acc, nxt_acc;
	logic        little_q, cur_little, nxt_little;
	logic [15:0] entries_q, cur_entries, nxt_entries;
	logic [2:0]  flags_q, cur_flags, nxt_flags;
	logic [15:0] held_q, cur_held, nxt_held;
	logic        given_q, cur_given, nxt_given;
	logic [15:0] len16;
	logic [31:0] acc_new;
	logic [31:0] skip_dec;
	logic [15:0] entries_dec;
	logic [2:0]  flags_hdr;
	logic        hit;
	logic [2:0]  hit_status;
	logic [3:0]  hit_orient;

	// a first byte restarts the file before the byte is parsed
	assign cur_phase   = first_byte ? PH_SOI : phase_q;
	assign cur_pos     = first_byte ? 4'd0 : pos_q;
	assign cur_skip    = first_byte ? 32'd0 : skip_q;
	assign cur_acc     = first_byte ? 32'd0 : acc_q;
	assign cur_little  = first_byte ? 1'b0 : little_q;
	assign cur_entries = first_byte ? 16'd0 : entries_q;
	assign cur_flags   = first_byte ? 3'd0 : flags_q;
	assign cur_held    = first_byte ? 16'd0 : held_q;
	assign cur_given   = first_byte ? 1'b0 : given_q;

	assign len16       = {cur_acc[7:0], data_byte};
	assign skip_dec    = cur_skip - 32'd1;
	assign entries_dec = cur_entries - 16'd1;

	// TIFF field accumulation for the current byte
	always_comb begin
		acc_new = cur_acc;
		case (cur_phase)
			PH_TIFF: acc_new = tiff_acc(cur_acc, cur_little, cur_pos[1:0], data_byte);
			PH_CNT:  acc_new = tiff_acc(cur_acc, cur_little, {1'b0, cur_pos[0]}, data_byte);
			PH_ENT: begin
				if (cur_pos == 4'd2 || cur_pos == 4'd3) begin
					acc_new = tiff_acc(cur_acc, cur_little, {1'b0, cur_pos[0]}, data_byte);
				end else begin
					acc_new = tiff_acc(cur_acc, cur_little, cur_pos[1:0], data_byte);
				end
			end
			default: acc_new = cur_acc;
		endcase
	end

	assign flags_hdr = (data_byte != exif_sig(cur_pos[2:0])) ? 3'd1 : cur_flags;

	// Next parse state and result for one accepted byte
	always_comb begin
		nxt_phase   = cur_phase;
		nxt_pos     = cur_pos;
		nxt_skip    = cur_skip;
		nxt_acc     = cur_acc;
		nxt_little  = cur_little;
		nxt_entries = cur_entries;
		nxt_flags   = cur_flags;
		nxt_held    = cur_held;
		nxt_given   = cur_given;
		hit         = 1'b0;
		hit_status  = ST_FOUND;
		hit_orient  = ORIENT_DEFAULT;

		if (!cur_given) begin
			case (cur_phase)
				PH_SOI: begin
					if (data_byte != ((cur_pos == 4'd0) ? MK_PREFIX : MK_SOI)) begin
						hit = 1'b1;
						hit_status = ST_NOT_JPEG;
					end else if (cur_pos == 4'd0) begin
						nxt_pos = 4'd1;
					end else begin
						nxt_phase = PH_MK0;
						nxt_pos = 4'd0;
					end
				end
				PH_MK0: begin
					if (data_byte != MK_PREFIX) begin
						hit = 1'b1;
						hit_status = ST_BAD_MARK;
					end else begin
						nxt_phase = PH_MK1;
					end
				end
				PH_MK1: begin
					nxt_pos = 4'd0;
					if (data_byte == MK_APP1) begin
						nxt_phase = PH_LEN_APP1;
					end else if (data_byte == MK_EOI) begin
						hit = 1'b1;
						hit_status = ST_EOI;
					end else if (data_byte == MK_STUFF || data_byte == MK_PREFIX ||
						(data_byte >= MK_RST_LO && data_byte <= MK_RST_HI)) begin
						nxt_phase = PH_MK0;
					end else begin
						nxt_phase = PH_LEN_SEG;
					end
				end
				PH_LEN_SEG, PH_LEN_APP1: begin
					if (cur_pos == 4'd0) begin
						nxt_acc = {24'd0, data_byte};
						nxt_pos = 4'd1;
					end else begin
						nxt_acc = {16'd0, len16};
						nxt_pos = 4'd0;
						if (cur_phase == PH_LEN_SEG) begin
							if (len16 < 16'd2) begin
								hit = 1'b1;
								hit_status = ST_BAD_LEN;
							end else begin
								nxt_skip = {16'd0, len16 - 16'd2};
								nxt_phase = (len16 != 16'd2) ? PH_SKIP_SEG : PH_MK0;
							end
						end else if (len16 < 16'd8) begin
							hit = 1'b1;
							hit_status = ST_BAD_LEN;
						end else begin
							nxt_held = len16;
							nxt_flags = 3'd0;
							nxt_phase = PH_EXHDR;
						end
					end
				end
				PH_SKIP_SEG, PH_SKIP_IFD: begin
					nxt_skip = skip_dec;
					nxt_pos = 4'd0;
					if (skip_dec == 32'd0) begin
						nxt_phase = (cur_phase == PH_SKIP_SEG) ? PH_MK0 : PH_CNT;
					end
				end
				PH_EXHDR: begin
					nxt_flags = flags_hdr;
					if (cur_pos < 4'd5) begin
						nxt_pos = cur_pos + 4'd1;
					end else begin
						nxt_pos = 4'd0;
						nxt_flags = 3'd0;
						if (flags_hdr != 3'd0) begin
							// not Exif: skip the rest of the APP1 segment
							nxt_skip = {16'd0, cur_held - 16'd8};
							nxt_phase = (cur_held != 16'd8) ? PH_SKIP_SEG : PH_MK0;
						end else begin
							nxt_phase = PH_TIFF;
						end
					end
				end
				PH_TIFF: begin
					if (cur_pos == 4'd0) begin
						nxt_little = (data_byte == TIFF_LE);
					end
					if (cur_pos >= 4'd4) begin
						nxt_acc = acc_new;
					end
					if (cur_pos < 4'd7) begin
						nxt_pos = cur_pos + 4'd1;
					end else begin
						nxt_pos = 4'd0;
						if (acc_new < 32'd8) begin
							hit = 1'b1;
							hit_status = ST_BAD_LEN;
						end else begin
							// IFD0 offset counts from the TIFF header start
							nxt_skip = acc_new - 32'd8;
							nxt_phase = (acc_new != 32'd8) ? PH_SKIP_IFD : PH_CNT;
						end
					end
				end
				PH_CNT: begin
					nxt_acc = acc_new;
					if (cur_pos == 4'd0) begin
						nxt_pos = 4'd1;
					end else begin
						nxt_pos = 4'd0;
						nxt_entries = acc_new[15:0];
						if (acc_new[15:0] == 16'd0) begin
							hit = 1'b1;
							hit_status = ST_ABSENT;
						end else begin
							nxt_flags = 3'd0;
							nxt_phase = PH_ENT;
						end
					end
				end
				PH_ENT: begin
					// tag, type, count and value fields of one twelve-byte entry
					if (cur_pos < 4'd10) begin
						nxt_acc = acc_new;
					end
					if (cur_pos == 4'd1 && acc_new == TAG_ORIENT) begin
						nxt_flags[0] = 1'b1;
					end
					if (cur_pos == 4'd3 && acc_new == TYPE_SHORT) begin
						nxt_flags[1] = 1'b1;
					end
					if (cur_pos == 4'd7 && acc_new == COUNT_ONE) begin
						nxt_flags[2] = 1'b1;
					end
					if (cur_pos == 4'd9) begin
						nxt_held = acc_new[15:0];
					end
					if (cur_pos < 4'd11) begin
						nxt_pos = cur_pos + 4'd1;
					end else begin
						nxt_pos = 4'd0;
						if (cur_flags == 3'b111) begin
							hit = 1'b1;
							if (cur_held >= 16'd1 && cur_held <= {12'd0, ORIENT_MAX}) begin
								hit_status = ST_FOUND;
								hit_orient = cur_held[3:0];
							end else begin
								hit_status = ST_RANGE;
							end
						end else begin
							nxt_flags = 3'd0;
							nxt_entries = entries_dec;
							if (entries_dec == 16'd0) begin
								hit = 1'b1;
								hit_status = ST_ABSENT;
							end
						end
					end
				end
				default: begin
					nxt_phase   = PH_SOI;
					nxt_pos     = 4'd0;
					nxt_skip    = 32'd0;
					nxt_acc     = 32'd0;
					nxt_little  = 1'b0;
					nxt_entries = 16'd0;
					nxt_flags   = 3'd0;
					nxt_held    = 16'd0;
				end
			endcase
			// end of file without a result
			if (!hit && last_byte) begin
				hit = 1'b1;
				hit_status = (nxt_phase == PH_SOI) ? ST_NOT_JPEG : ST_TRUNC;
			end
		end

		if (hit) begin
			nxt_given = 1'b1;
		end

		// a last byte leaves the parser ready for the next file
		if (last_byte) begin
			nxt_phase   = PH_SOI;
			nxt_pos     = 4'd0;
			nxt_skip    = 32'd0;
			nxt_acc     = 32'd0;
			nxt_little  = 1'b0;
			nxt_entries = 16'd0;
			nxt_flags   = 3'd0;
			nxt_held    = 16'd0;
			nxt_given   = 1'b0;
		end
	end

	assign res.valid       = hit;
	assign res.status      = hit_status;
	assign res.orientation = hit_orient;

	// Advance the parse state on each transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_SOI;
			pos_q     <= 4'd0;
			skip_q    <= 32'd0;
			acc_q     <= 32'd0;
			little_q  <= 1'b0;
			entries_q <= 16'd0;
			flags_q   <= 3'd0;
			held_q    <= 16'd0;
			given_q   <= 1'b0;
		end else if (take) begin
			phase_q   <= nxt_phase;
			pos_q     <= nxt_pos;
			skip_q    <= nxt_skip;
			acc_q     <= nxt_acc;
			little_q  <= nxt_little;
			entries_q <= nxt_entries;
			flags_q   <= nxt_flags;
			held_q    <= nxt_held;
			given_q   <= nxt_given;
		end
	end

	`JEOP_ASSERT_IMP(a_one_result, clk, arst_n, take && res.valid, !given_q || first_byte)
	`JEOP_ASSERT_NXT(a_last_clears, clk, arst_n, take && last_byte,
		phase_q == PH_SOI && !given_q && pos_q == 4'd0)
	`JEOP_ASSERT_IMP(a_found_range, clk, arst_n, res.valid && res.status == ST_FOUND,
		res.orientation != 4'd0 && res.orientation <= ORIENT_MAX)

endmodule

/* sv/jeop_out_reg.sv */
// Result register of the Exif orientation parser, parting input and output handshakes.
// Depends on jeop_pkg and the core assertion macro header.
`include "jpeg_exif_orientation_parser_core_defines.svh"
module jeop_out_reg (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           take,
	input  jeop_pkg::result_t              res,
	output logic                           free,
	output logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	output logic [jeop_pkg::TDATA_W-1:0]   m_axis_tdata
);
	import jeop_pkg::*;

	logic       valid_q;
	logic [2:0] status_q;
	logic [3:0] orient_q;

	// Room for a new result when empty or draining this cycle
	assign free = !valid_q || m_axis_tready;

	// Hold a result until its transfer completes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (take && res.valid) begin
			valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			valid_q <= 1'b0;
		end
	end

	// Load payload with each new result
	always_ff @(posedge clk) begin
		if (take && res.valid) begin
			status_q <= res.status;
			orient_q <= res.orientation;
		end
	end

	assign m_axis_tvalid = valid_q;
	assign m_axis_tdata  = {1'b0, status_q, orient_q};

	`JEOP_ASSERT_NXT(a_load_shows, clk, arst_n, take && res.valid, m_axis_tvalid)
	`JEOP_ASSERT_IMP(a_empty_free, clk, arst_n, !valid_q, free)
	`JEOP_ASSERT_IMP(a_default_orient, clk, arst_n, valid_q && status_q != ST_FOUND,
		orient_q == ORIENT_DEFAULT)

endmodule

/* sv/jpeg_exif_orientation_parser_core.sv */
// JPEG Exif orientation parser: one file byte per transfer, one result per file.
// Throughput: one byte per cycle; the input is stalled only while a result waits unread.
// A result is shown on m_axis in the cycle after the byte that decides it is taken.
// Parse state is updated once per accepted byte by the marker/IFD state machine.
// Reset (arst_n low): parse state returns to awaiting start of image, output empties.
// Depends on jeop_pkg, jeop_parser and jeop_out_reg.
module jpeg_exif_orientation_parser_core (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_axis_tvalid,
	output logic                           s_axis_tready,
	input  logic [7:0]                     s_axis_tdata,  // [7:0] data_byte
	input  logic                           s_axis_tuser,  // [0] first_byte
	input  logic                           s_axis_tlast,  // last_byte
	output logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	output logic [jeop_pkg::TDATA_W-1:0]   m_axis_tdata   // [3:0] orientation, [6:4] status
);
	import jeop_pkg::*;

	logic    take;
	logic    free;
	result_t res;

	// Accept a byte whenever the result register has room
	assign s_axis_tready = free;
	assign take = s_axis_tvalid && free;

	jeop_parser u_parser (
		.clk        (clk),
		.arst_n     (arst_n),
		.take       (take),
		.data_byte  (s_axis_tdata),
		.first_byte (s_axis_tuser),
		.last_byte  (s_axis_tlast),
		.res        (res)
	);

	jeop_out_reg u_out_reg (
		.clk           (clk),
		.arst_n        (arst_n),
		.take          (take),
		.res           (res),
		.free          (free),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

endmodule
